FILE: design/xrd_pkg.sv
package xrd_pkg;

   localparam logic [63:0] GAMMA_K = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] MIX_A_K = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MIX_B_K = 64'h94D049BB133111EB;

   localparam logic [2:0] MODE_LONG  = 3'd0;
   localparam logic [2:0] MODE_INT   = 3'd1;
   localparam logic [2:0] MODE_BELOW = 3'd2;
   localparam logic [2:0] MODE_RANGE = 3'd3;
   localparam logic [2:0] MODE_INCL  = 3'd4;
   localparam logic [2:0] MODE_BOOL  = 3'd5;

   typedef enum logic [1:0] {
      DR_SEED,
      DR_IDLE,
      DR_DIV,
      DR_FINISH
   } draw_state_type;

   typedef enum logic [2:0] {
      SD_IDLE,
      SD_LOAD,
      SD_MULA,
      SD_MID,
      SD_MULB,
      SD_STORE
   } seed_state_type;

   typedef struct packed {
      logic        start;
      logic [63:0] seed;
   } seed_ctrl_type;

   typedef struct packed {
      logic        done;
      logic [63:0] word_a;
      logic [63:0] word_b;
   } seed_status_type;

endpackage

FILE: design/xrd_intf.sv
interface xrd_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         mode;
   logic signed [31:0] bound_low;
   logic signed [31:0] bound_high;

   modport source (output valid, mode, bound_low, bound_high, input ready);
   modport sink (input valid, mode, bound_low, bound_high, output ready);
endinterface

interface xrd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] value;
   logic               divide_fault;

   modport source (output valid, value, divide_fault, input ready);
   modport sink (input valid, value, divide_fault, output ready);
endinterface

interface xrd_csr_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] seed;

   modport source (output valid, seed, input ready);
   modport sink (input valid, seed, output ready);
endinterface

FILE: design/xrd_seeder.sv
module xrd_seeder (
   input  logic                     clock,
   input  logic                     reset,
   input  xrd_pkg::seed_ctrl_type   ctrl,
   output xrd_pkg::seed_status_type stat
);
   import xrd_pkg::*;

   localparam logic [5:0] MulLast = 6'd63;

   seed_state_type state_ff, state_in;
   logic [63:0] zbase_ff, zbase_in;
   logic [63:0] mcand_ff, mcand_in;
   logic [63:0] mplier_ff, mplier_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] first_ff, first_in;
   logic        sel_ff, sel_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] sum;
   logic [63:0] mixed;
   logic        both_zero;

   // One multiplier bit per cycle: shift-and-add keeps the low 64 bits only.
   assign sum       = acc_ff + (mplier_ff[0] ? mcand_ff : 64'd0);
   assign mixed     = acc_ff ^ (acc_ff >> 31);
   assign both_zero = (first_ff == 64'd0) && (mixed == 64'd0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SD_IDLE: begin
            if (ctrl.start) state_in = SD_LOAD;
         end
         SD_LOAD:  state_in = SD_MULA;
         SD_MULA: begin
            if (cnt_ff == MulLast) state_in = SD_MID;
         end
         SD_MID:   state_in = SD_MULB;
         SD_MULB: begin
            if (cnt_ff == MulLast) state_in = SD_STORE;
         end
         SD_STORE: state_in = sel_ff ? SD_IDLE : SD_LOAD;
         default:  state_in = SD_IDLE;
      endcase
   end

   always_comb begin
      zbase_in  = zbase_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      first_in  = first_ff;
      sel_in    = sel_ff;
      cnt_in    = cnt_ff;
      case (state_ff)
         SD_IDLE: begin
            if (ctrl.start) begin
               zbase_in = ctrl.seed + GAMMA_K;
               sel_in   = 1'b0;
            end
         end
         SD_LOAD: begin
            mcand_in  = zbase_ff ^ (zbase_ff >> 30);
            mplier_in = MIX_A_K;
            acc_in    = 64'd0;
            cnt_in    = 6'd0;
         end
         SD_MULA, SD_MULB: begin
            acc_in    = sum;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + 6'd1;
         end
         SD_MID: begin
            mcand_in  = acc_ff ^ (acc_ff >> 27);
            mplier_in = MIX_B_K;
            acc_in    = 64'd0;
            cnt_in    = 6'd0;
         end
         SD_STORE: begin
            if (!sel_ff) begin
               first_in = mixed;
               zbase_in = zbase_ff + GAMMA_K;
               sel_in   = 1'b1;
            end
         end
         default: begin
            sel_in = sel_ff;
         end
      endcase
   end

   assign stat.done   = (state_ff == SD_STORE) && sel_ff;
   assign stat.word_a = both_zero ? GAMMA_K : first_ff;
   assign stat.word_b = both_zero ? ~GAMMA_K : mixed;

   // Reset starts a reload from seed zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SD_LOAD;
         zbase_ff <= GAMMA_K;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         zbase_ff <= zbase_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      first_ff  <= first_in;
      cnt_ff    <= cnt_in;
   end

endmodule

FILE: design/xoroshiro128pp_random_draw_unit.sv
// xoroshiro128++ draw unit.
// req_port carries one draw request per beat: mode, bound_low and bound_high.
// rsp_port returns one beat per request: the drawn value and divide_fault.
// csr_port takes the 64-bit seed; a write reloads the generator through two
// splitmix64 rounds and is taken only while the unit is idle.
// The splitmix64 multiplies run bit-serially in a shift-and-add unit, one
// multiplier bit per cycle. Reset starts the same reload with seed zero;
// req_ready and csr_ready stay low until it ends. Long, int and boolean
// draws, bound draws with a zero bound, range draws with a zero span and
// unused modes go straight to the finish state. Below, inclusive and the
// other range draws run a restoring remainder over the 31 draw bits, one
// bit per cycle, before the finish state. From the finish state the result
// is registered into the output register once it is free; only then is a
// new request accepted. The result sits in an output register; while the
// receiver stalls, the next request is still accepted and worked on, and
// its result waits in the unit until the output register is free.
module xoroshiro128pp_random_draw_unit (
   input logic        clock,
   input logic        reset,
   xrd_req_if.sink    req_port,
   xrd_rsp_if.source  rsp_port,
   xrd_csr_if.sink    csr_port
);
   import xrd_pkg::*;

   localparam logic [4:0] DivLast = 5'd30;

   draw_state_type  state_ff, state_in;
   seed_ctrl_type   seed_ctrl;
   seed_status_type seed_stat;

   logic [63:0] word_a_ff, word_a_in;
   logic [63:0] word_b_ff, word_b_in;
   logic [2:0]  mode_ff, mode_in;
   logic [31:0] low_ff, low_in;
   logic [63:0] rnd_ff, rnd_in;
   logic [31:0] mag_ff, mag_in;
   logic        zero_ff, zero_in;
   logic [30:0] num_ff, num_in;
   logic [31:0] rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_value_ff, rsp_value_in;
   logic        rsp_fault_ff, rsp_fault_in;

   logic        req_take;
   logic        csr_take;
   logic        out_free;
   logic [31:0] divisor;
   logic        div_zero;
   logic        take_draw;
   logic        needs_div;
   logic [63:0] step_sum;
   logic [63:0] step_out;
   logic [63:0] step_x;
   logic [63:0] next_a;
   logic [63:0] next_b;
   logic [31:0] trial;
   logic [31:0] range_sum;
   logic [63:0] result_value;
   logic        result_fault;

   assign csr_port.ready = (state_ff == DR_IDLE);
   assign req_port.ready = (state_ff == DR_IDLE) && !csr_port.valid;
   assign csr_take       = csr_port.valid && csr_port.ready;
   assign req_take       = req_port.valid && req_port.ready;
   assign out_free       = !rsp_valid_ff || rsp_port.ready;

   assign seed_ctrl.start = csr_take;
   assign seed_ctrl.seed  = csr_port.seed;

   xrd_seeder u_seeder (
      .clock (clock),
      .reset (reset),
      .ctrl  (seed_ctrl),
      .stat  (seed_stat)
   );

   // Divisor of the request, wrapped to 32 bits.
   always_comb begin
      case (req_port.mode)
         MODE_RANGE: divisor = req_port.bound_high - req_port.bound_low;
         MODE_INCL:  divisor = req_port.bound_high + 32'd1;
         default:    divisor = req_port.bound_high;
      endcase
   end

   assign div_zero = (divisor == 32'd0);

   always_comb begin
      case (req_port.mode)
         MODE_LONG, MODE_INT, MODE_BOOL, MODE_RANGE: take_draw = 1'b1;
         MODE_BELOW, MODE_INCL:                      take_draw = !div_zero;
         default:                                    take_draw = 1'b0;
      endcase
   end

   assign needs_div = (req_port.mode inside {MODE_BELOW, MODE_INCL, MODE_RANGE}) && !div_zero;

   // One xoroshiro128++ step.
   assign step_sum = word_a_ff + word_b_ff;
   assign step_out = {step_sum[46:0], step_sum[63:47]} + word_a_ff;
   assign step_x   = word_a_ff ^ word_b_ff;
   assign next_a   = {word_a_ff[14:0], word_a_ff[63:15]} ^ step_x ^ (step_x << 21);
   assign next_b   = {step_x[35:0], step_x[63:36]};

   assign trial     = {rem_ff[30:0], num_ff[30]};
   assign range_sum = low_ff + rem_ff;

   always_comb begin
      result_fault = 1'b0;
      case (mode_ff)
         MODE_LONG:  result_value = rnd_ff;
         MODE_INT:   result_value = {33'd0, rnd_ff[30:0]};
         MODE_BELOW, MODE_INCL: begin
            result_value = zero_ff ? 64'd0 : {32'd0, rem_ff};
         end
         MODE_RANGE: begin
            if (zero_ff) begin
               result_value = {{32{low_ff[31]}}, low_ff};
               result_fault = 1'b1;
            end else begin
               result_value = {{32{range_sum[31]}}, range_sum};
            end
         end
         MODE_BOOL:  result_value = {63'd0, rnd_ff[0]};
         default:    result_value = 64'd0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         DR_SEED: begin
            if (seed_stat.done) state_in = DR_IDLE;
         end
         DR_IDLE: begin
            if (csr_take) begin
               state_in = DR_SEED;
            end else if (req_take) begin
               state_in = needs_div ? DR_DIV : DR_FINISH;
            end
         end
         DR_DIV: begin
            if (cnt_ff == DivLast) state_in = DR_FINISH;
         end
         DR_FINISH: begin
            if (out_free) state_in = DR_IDLE;
         end
         default: state_in = DR_SEED;
      endcase
   end

   always_comb begin
      word_a_in    = word_a_ff;
      word_b_in    = word_b_ff;
      mode_in      = mode_ff;
      low_in       = low_ff;
      rnd_in       = rnd_ff;
      mag_in       = mag_ff;
      zero_in      = zero_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      rsp_value_in = rsp_value_ff;
      rsp_fault_in = rsp_fault_ff;
      case (state_ff)
         DR_SEED: begin
            if (seed_stat.done) begin
               word_a_in = seed_stat.word_a;
               word_b_in = seed_stat.word_b;
            end
         end
         DR_IDLE: begin
            if (req_take) begin
               mode_in = req_port.mode;
               low_in  = req_port.bound_low;
               rnd_in  = step_out;
               zero_in = div_zero;
               // A divisor of -2^31 gives a magnitude of 2^31 here.
               mag_in  = divisor[31] ? (~divisor + 32'd1) : divisor;
               num_in  = step_out[30:0];
               rem_in  = 32'd0;
               cnt_in  = 5'd0;
               if (take_draw) begin
                  word_a_in = next_a;
                  word_b_in = next_b;
               end
            end
         end
         DR_DIV: begin
            rem_in = (trial >= mag_ff) ? (trial - mag_ff) : trial;
            num_in = num_ff << 1;
            cnt_in = cnt_ff + 5'd1;
         end
         DR_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = result_value;
               rsp_fault_in = result_fault;
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.value        = rsp_value_ff;
   assign rsp_port.divide_fault = rsp_fault_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= DR_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_a_ff    <= word_a_in;
      word_b_ff    <= word_b_in;
      mode_ff      <= mode_in;
      low_ff       <= low_in;
      rnd_ff       <= rnd_in;
      mag_ff       <= mag_in;
      zero_ff      <= zero_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      rsp_value_ff <= rsp_value_in;
      rsp_fault_ff <= rsp_fault_in;
   end

endmodule

FILE: design/xrd_checker.sv
module xrd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_value,
   input logic        rsp_divide_fault,
   input logic        csr_valid,
   input logic        csr_ready
);

   // A waiting result beat stays offered until it is taken.
   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // Reset starts a reload, so nothing is taken in the next cycle.
   reset_reload: assert property (@(posedge clock)
      reset |=> !req_ready && !csr_ready)
      else $error("unit ready right after reset");

   // A seed write starts a reload that blocks both request and seed ports.
   seed_reload: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_ready && !csr_ready)
      else $error("unit ready right after a seed write");

   // Requests are worked on one at a time.
   one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted in back-to-back cycles");

   // A faulted range draw returns the sign-extended lower end.
   fault_sext: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_fault |-> rsp_value[63:32] == {32{rsp_value[31]}})
      else $error("faulted result is not sign-extended");

endmodule

bind xoroshiro128pp_random_draw_unit xrd_checker u_xrd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_port.valid),
   .req_ready        (req_port.ready),
   .rsp_valid        (rsp_port.valid),
   .rsp_ready        (rsp_port.ready),
   .rsp_value        (rsp_port.value),
   .rsp_divide_fault (rsp_port.divide_fault),
   .csr_valid        (csr_port.valid),
   .csr_ready        (csr_port.ready)
);

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
   import xrd_pkg::*;

   localparam int CYCLE_LIMIT = 400_000;
   localparam int PHASE_COUNT = 9;
   localparam int DRAWS_PER_PHASE = 128;
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      logic [2:0]  mode;
      logic [31:0] low;
      logic [31:0] high;
   } draw_req_type;

   typedef struct {
      logic [63:0] value;
      logic        divide_fault;
   } draw_result_type;

   logic clock;
   logic reset;

   xrd_req_if req_if ();
   xrd_rsp_if rsp_if ();
   xrd_csr_if csr_if ();

   xoroshiro128pp_random_draw_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   // Generator state as the predictor sees it.
   logic [63:0] gen_a;
   logic [63:0] gen_b;

   draw_req_type    draw_requests[$];
   draw_result_type awaited_draws[$];
   draw_req_type    next_req;
   draw_result_type got_want;

   int  draws_queued;
   int  draws_done;
   int  mismatches;
   int  cycle_count;
   int  seed_loads;
   int  fault_count;
   int  zero_bound_count;
   int  req_gap;
   int  rsp_stall;
   int  req_idle_pct;
   int  rsp_stall_pct;
   bit  req_beat;

   always #10 clock = ~clock;

   function automatic logic [63:0] rotl64(logic [63:0] v, int unsigned k);
      return (v << k) | (v >> (64 - k));
   endfunction

   function automatic logic [63:0] splitmix_scramble(logic [63:0] z);
      z = (z ^ (z >> 30)) * MIX_A_K;
      z = (z ^ (z >> 27)) * MIX_B_K;
      return z ^ (z >> 31);
   endfunction

   function automatic void reseed_generator(logic [63:0] s);
      logic [63:0] z;
      z = s + GAMMA_K;
      gen_a = splitmix_scramble(z);
      z = z + GAMMA_K;
      gen_b = splitmix_scramble(z);
      if (gen_a == 64'd0 && gen_b == 64'd0) begin
         gen_a = GAMMA_K;
         gen_b = ~GAMMA_K;
      end
   endfunction

   function automatic logic [63:0] step_generator();
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] r;
      a = gen_a;
      b = gen_b;
      r = rotl64(a + b, 17) + a;
      b = b ^ a;
      gen_a = rotl64(a, 49) ^ b ^ (b << 21);
      gen_b = rotl64(b, 28);
      return r;
   endfunction

   // Remainder by the magnitude of a 32-bit divisor; -2^31 divides by 2^31.
   function automatic logic [31:0] reduce31(logic [30:0] n, logic [31:0] d);
      logic [31:0] m;
      m = d[31] ? -d : d;
      if (m == 32'h8000_0000)
         return {1'b0, n};
      return {1'b0, n} % m;
   endfunction

   function automatic logic [31:0] draw_below(logic [31:0] bound);
      logic [63:0] w;
      if (bound == 32'd0) begin
         // No draw is made, so the generator does not advance.
         zero_bound_count++;
         return 32'd0;
      end
      w = step_generator();
      return reduce31(w[30:0], bound);
   endfunction

   function automatic draw_result_type next_draw_result(draw_req_type q);
      draw_result_type res;
      logic [63:0]     w;
      logic [31:0]     span;
      logic [31:0]     sum;
      res.value = 64'd0;
      res.divide_fault = 1'b0;
      case (q.mode)
         MODE_LONG: res.value = step_generator();
         MODE_INT: begin
            w = step_generator();
            res.value = {33'd0, w[30:0]};
         end
         MODE_BELOW: res.value = {32'd0, draw_below(q.high)};
         MODE_INCL: res.value = {32'd0, draw_below(q.high + 32'd1)};
         MODE_RANGE: begin
            span = q.high - q.low;
            w = step_generator();
            if (span == 32'd0) begin
               res.value = {{32{q.low[31]}}, q.low};
               res.divide_fault = 1'b1;
               fault_count++;
            end else begin
               sum = q.low + reduce31(w[30:0], span);
               res.value = {{32{sum[31]}}, sum};
            end
         end
         MODE_BOOL: begin
            w = step_generator();
            res.value = {63'd0, w[0]};
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic logic [31:0] pick_operand();
      logic [31:0] x;
      case ($urandom_range(9))
         0, 1, 2: x = $urandom_range(40);
         3: x = -$urandom_range(40);
         4: begin
            case ($urandom_range(5))
               0: x = 32'd0;
               1: x = 32'hFFFF_FFFF;
               2: x = 32'h7FFF_FFFF;
               3: x = 32'h8000_0000;
               4: x = 32'h8000_0001;
               default: x = 32'd1;
            endcase
         end
         5: x = 32'd1 << $urandom_range(31);
         6: x = -(32'd1 << $urandom_range(31));
         default: x = $urandom;
      endcase
      return x;
   endfunction

   task automatic enqueue_draw(logic [2:0] m, logic [31:0] lo, logic [31:0] hi);
      draw_req_type q;
      q.mode = m;
      q.low = lo;
      q.high = hi;
      draw_requests.push_back(q);
      draws_queued++;
   endtask

   task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch on result %0d, %s: expected %h, got %h",
                  draws_done, what, want, got);
   endtask

   // Request driver: a beat is held until taken, and gaps go only between beats.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_if.valid && !req_beat) begin
      end else if (req_gap != 0) begin
         req_gap--;
         req_if.valid <= 1'b0;
      end else if (draw_requests.size() != 0 && req_idle_pct != 0 &&
                   $urandom_range(99) < req_idle_pct) begin
         req_gap = $urandom_range(15, 1) - 1;
         req_if.valid <= 1'b0;
      end else if (draw_requests.size() != 0) begin
         next_req = draw_requests.pop_front();
         req_if.valid <= 1'b1;
         req_if.mode <= next_req.mode;
         req_if.bound_low <= next_req.low;
         req_if.bound_high <= next_req.high;
      end else begin
         req_if.valid <= 1'b0;
      end
   end

   // Result receiver back-pressure.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_stall != 0) begin
         rsp_stall--;
         rsp_if.ready <= 1'b0;
      end else if (rsp_stall_pct != 0 && $urandom_range(99) < rsp_stall_pct) begin
         rsp_stall = $urandom_range(15, 1) - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Monitor: predict on every request beat, check every result beat.
   always @(posedge clock) begin
      cycle_count++;
      req_beat = !reset && req_if.valid && req_if.ready;
      if (req_beat) begin
         next_req.mode = req_if.mode;
         next_req.low = req_if.bound_low;
         next_req.high = req_if.bound_high;
         awaited_draws.push_back(next_draw_result(next_req));
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (awaited_draws.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result beat with no request outstanding: value %h fault %b",
                        rsp_if.value, rsp_if.divide_fault);
         end else begin
            got_want = awaited_draws.pop_front();
            if (rsp_if.value !== got_want.value)
               report_mismatch("value", got_want.value, rsp_if.value);
            if (rsp_if.divide_fault !== got_want.divide_fault)
               report_mismatch("divide_fault", {63'd0, got_want.divide_fault},
                               {63'd0, rsp_if.divide_fault});
            draws_done++;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("timeout after %0d cycles with %0d of %0d results checked",
               cycle_count, draws_done, draws_queued);
      $display("tb failed");
      $finish;
   end

   initial begin
      logic [63:0] seed_plan[PHASE_COUNT];
      logic [2:0]  m;
      logic [31:0] lo;
      logic [31:0] hi;
      int          sel;
      int          odds[4];

      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.mode = MODE_LONG;
      req_if.bound_low = '0;
      req_if.bound_high = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.seed = '0;
      req_beat = 1'b0;
      req_gap = 0;
      rsp_stall = 0;
      req_idle_pct = 20;
      rsp_stall_pct = 20;
      odds = '{0, 5, 15, 40};

      seed_plan[0] = 64'h8000_0000_0000_0000;
      seed_plan[1] = 64'h7FFF_FFFF_FFFF_FFFF;
      seed_plan[2] = 64'hFFFF_FFFF_FFFF_FFFF;
      seed_plan[3] = 64'd0;
      // These two seeds make the first or the second state word come out zero.
      seed_plan[4] = 64'd0 - GAMMA_K;
      seed_plan[5] = 64'd0 - GAMMA_K - GAMMA_K;
      for (int i = 6; i < PHASE_COUNT; i++)
         seed_plan[i] = {$urandom, $urandom};

      // The block comes out of reset with the state of seed zero.
      reseed_generator(64'd0);
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      enqueue_draw(MODE_LONG, 32'd0, 32'd0);
      enqueue_draw(MODE_INT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      enqueue_draw(MODE_BOOL, 32'h8000_0000, 32'h7FFF_FFFF);
      enqueue_draw(MODE_BELOW, 32'd0, 32'd0);
      enqueue_draw(MODE_BELOW, 32'd0, 32'd1);
      enqueue_draw(MODE_BELOW, 32'd0, 32'hFFFF_FFFF);
      enqueue_draw(MODE_BELOW, 32'd0, 32'h7FFF_FFFF);
      enqueue_draw(MODE_BELOW, 32'd0, 32'h8000_0000);
      enqueue_draw(MODE_BELOW, 32'd0, -32'd7);
      enqueue_draw(MODE_BELOW, 32'd0, 32'd1000);
      enqueue_draw(MODE_INCL, 32'd0, 32'hFFFF_FFFF);
      enqueue_draw(MODE_INCL, 32'd0, 32'd0);
      enqueue_draw(MODE_INCL, 32'd0, 32'h7FFF_FFFF);
      enqueue_draw(MODE_INCL, 32'd0, -32'd2);
      enqueue_draw(MODE_INCL, 32'd0, 32'd9);
      enqueue_draw(MODE_RANGE, 32'd5, 32'd5);
      enqueue_draw(MODE_RANGE, 32'h8000_0000, 32'h8000_0000);
      enqueue_draw(MODE_RANGE, 32'd0, 32'h8000_0000);
      enqueue_draw(MODE_RANGE, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      enqueue_draw(MODE_RANGE, 32'h7FFF_FFF0, 32'h8000_0010);
      enqueue_draw(MODE_RANGE, 32'd10, 32'd3);
      enqueue_draw(MODE_RANGE, 32'h8000_0000, 32'h7FFF_FFFF);
      wait (draws_done == draws_queued);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p == PHASE_COUNT - 1) begin
            req_idle_pct = 0;
            rsp_stall_pct = 0;
         end else begin
            req_idle_pct = odds[$urandom_range(3)];
            rsp_stall_pct = odds[$urandom_range(3)];
         end

         // Seed writes happen only with nothing in flight.
         @(negedge clock);
         csr_if.valid <= 1'b1;
         csr_if.seed <= seed_plan[p];
         do @(posedge clock); while (csr_if.ready !== 1'b1);
         reseed_generator(seed_plan[p]);
         seed_loads++;
         @(negedge clock);
         csr_if.valid <= 1'b0;

         for (int i = 0; i < DRAWS_PER_PHASE; i++) begin
            sel = $urandom_range(99);
            if (sel < 10)
               m = MODE_LONG;
            else if (sel < 20)
               m = MODE_INT;
            else if (sel < 42)
               m = MODE_BELOW;
            else if (sel < 70)
               m = MODE_RANGE;
            else if (sel < 90)
               m = MODE_INCL;
            else
               m = MODE_BOOL;
            lo = $urandom;
            hi = $urandom;
            if (m == MODE_BELOW) begin
               hi = pick_operand();
            end else if (m == MODE_INCL) begin
               hi = pick_operand() - $urandom_range(1);
            end else if (m == MODE_RANGE) begin
               lo = pick_operand();
               if ($urandom_range(3) != 0)
                  hi = lo + pick_operand();
               else
                  hi = pick_operand();
            end
            enqueue_draw(m, lo, hi);
         end
         wait (draws_done == draws_queued);
      end

      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Checked %0d draws over the reset seed and %0d seed writes.",
               draws_done, seed_loads);
      $display("%0d range draws had a zero span and %0d bound draws a zero bound.",
               fault_count, zero_bound_count);
      if (mismatches == 0 && awaited_draws.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches,
                  awaited_draws.size());
         $display("tb failed");
      end
      $finish;
   end

endmodule
